// ===== sv/urc_pkg.sv =====
`default_nettype none
package urc_pkg;

    localparam int TIME_BITS = 16;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam int WIDTH_BITS = 16;
    localparam int DIST_BITS  = 14;
    localparam int DEB_BITS   = 16;
    localparam int TRIG_BITS  = 8;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER  = 2'd1;

    localparam logic [DEB_BITS-1:0]  DEBOUNCE_RESET = 16'd1000;
    localparam logic [TRIG_BITS-1:0] TRIGGER_RESET  = 8'd20;

    // floor(w*10/58) = floor(5w/29) = (5w * ceil(2^24/29)) >> 24, exact for 5w < 2^24/9
    localparam int SCALED_BITS = WIDTH_BITS + 3;
    localparam int RECIP_BITS  = 20;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_BITS   = SCALED_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_29 = 20'd578525;

    localparam logic [DIST_BITS-1:0] DIST_MAX = 14'd11299;

    typedef struct packed {
        logic button_level;
        logic echo_level;
    } in_t;

    typedef struct packed {
        logic                  trigger_level;
        logic                  distance_valid;
        logic [DIST_BITS-1:0]  distance_mm;
        logic [WIDTH_BITS-1:0] echo_width_us;
    } out_t;

endpackage
`default_nettype wire

// ===== sv/urc_dist.sv =====
`default_nettype none
module urc_dist (
    input  wire logic [urc_pkg::WIDTH_BITS-1:0] width_us,
    output logic      [urc_pkg::DIST_BITS-1:0]  distance_mm
);
    import urc_pkg::*;

    logic [SCALED_BITS-1:0] scaled;
    logic [PROD_BITS-1:0]   prod;

    // 5 * width as shift and add
    assign scaled = SCALED_BITS'({width_us, 2'b00}) + SCALED_BITS'(width_us);
    assign prod   = PROD_BITS'(scaled) * PROD_BITS'(RECIP_29);
    assign distance_mm = prod[RECIP_SHIFT +: DIST_BITS];

endmodule
`default_nettype wire

// ===== sv/urc_core.sv =====
`default_nettype none
module urc_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          take,
    input  wire urc_pkg::in_t                  item,
    input  wire logic [urc_pkg::DEB_BITS-1:0]  debounce_us,
    input  wire logic [urc_pkg::TRIG_BITS-1:0] trigger_us,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output urc_pkg::out_t                      m_data,
    output logic                               out_ready
);
    import urc_pkg::*;

    logic                  button_prev_reg, button_prev_next;
    logic                  echo_prev_reg, echo_prev_next;
    logic [TIME_BITS-1:0]  since_press_reg, since_press_next;
    logic [TRIG_BITS-1:0]  trigger_left_reg, trigger_left_next;
    logic [TIME_BITS-1:0]  echo_count_reg, echo_count_next;
    logic [WIDTH_BITS-1:0] last_width_reg, last_width_next;
    logic [DIST_BITS-1:0]  last_distance_reg, last_distance_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    logic [TIME_BITS-1:0]  since_inc;
    logic [TIME_BITS-1:0]  echo_inc;
    logic                  rise;
    logic                  press_ok;
    logic [TRIG_BITS-1:0]  trig_load;
    logic                  trig;
    logic                  valid;
    logic [WIDTH_BITS-1:0] clamped;
    logic [DIST_BITS-1:0]  dist_mm;

    assign out_ready = !m_valid_reg || m_ready;

    assign since_inc = (since_press_reg == TIME_MAX) ? TIME_MAX : since_press_reg + 1'b1;
    assign echo_inc  = (echo_count_reg == TIME_MAX) ? TIME_MAX : echo_count_reg + 1'b1;
    assign rise      = item.button_level && !button_prev_reg;
    // a saturated timer always counts as long ago
    assign press_ok  = rise && ((32'(since_inc) >= 32'(debounce_us)) || (since_inc == TIME_MAX));
    assign trig_load = press_ok ? trigger_us : trigger_left_reg;
    assign trig      = (trig_load != '0);
    assign clamped   = (32'(echo_count_reg) > 32'(16'hFFFF)) ? 16'hFFFF
                                                              : echo_count_reg[WIDTH_BITS-1:0];

    urc_dist u_dist (
        .width_us    (clamped),
        .distance_mm (dist_mm)
    );

    always_comb begin
        button_prev_next   = button_prev_reg;
        echo_prev_next     = echo_prev_reg;
        since_press_next   = since_press_reg;
        trigger_left_next  = trigger_left_reg;
        echo_count_next    = echo_count_reg;
        last_width_next    = last_width_reg;
        last_distance_next = last_distance_reg;
        m_data_next        = m_data_reg;
        valid              = 1'b0;
        m_valid_next       = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (take) begin
            button_prev_next  = item.button_level;
            since_press_next  = rise ? '0 : since_inc;
            trigger_left_next = trig ? trig_load - 1'b1 : '0;
            echo_prev_next    = item.echo_level;
            if (item.echo_level) begin
                echo_count_next = echo_prev_reg ? echo_inc : TIME_BITS'(1);
            end else if (echo_prev_reg) begin
                last_width_next    = clamped;
                last_distance_next = dist_mm;
                valid              = 1'b1;
            end
            m_data_next.trigger_level  = trig;
            m_data_next.distance_valid = valid;
            m_data_next.distance_mm    = last_distance_next;
            m_data_next.echo_width_us  = last_width_next;
            m_valid_next               = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_prev_reg   <= 1'b0;
            echo_prev_reg     <= 1'b0;
            since_press_reg   <= TIME_MAX;
            trigger_left_reg  <= '0;
            echo_count_reg    <= '0;
            last_width_reg    <= '0;
            last_distance_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            button_prev_reg   <= button_prev_next;
            echo_prev_reg     <= echo_prev_next;
            since_press_reg   <= since_press_next;
            trigger_left_reg  <= trigger_left_next;
            echo_count_reg    <= echo_count_next;
            last_width_reg    <= last_width_next;
            last_distance_reg <= last_distance_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== sv/ultrasonic_ranger_controller.sv =====
// Ultrasonic ranger controller, one request per microsecond tick.
// Input channel (s_valid/s_ready/s_data): one request per tick with the
// sampled button and echo pin levels.
// Result channel (m_valid/m_ready/m_data): exactly one result per request with
// the trigger drive, a measurement-done flag, and the last width and distance.
// Configuration: cfg_we/cfg_addr/cfg_wdata; index 0 debounce_us, index 1
// trigger_us; other indexes are ignored. Write only while idle.
// Path: an accepted request goes into the input register, then the state update
// moves it into the result register, where m_valid rises with its result.
// Throughput: one request per cycle unless the result channel stalls; the
// distance path is a single 19x20 multiply by the reciprocal of 29 between
// the input and result registers.
// Stall: while m_ready is low the result holds, one more request is taken
// into the input register, then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): pipeline empty, press timer saturated,
// counters and last measurement cleared, registers back to 1000 and 20.
`default_nettype none
module ultrasonic_ranger_controller (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire urc_pkg::in_t                      s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output urc_pkg::out_t                          m_data,
    input  wire logic                              cfg_we,
    input  wire logic [urc_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
    input  wire logic [urc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
    import urc_pkg::*;

    logic                 in_valid_reg, in_valid_next;
    in_t                  in_data_reg;
    logic [DEB_BITS-1:0]  debounce_reg;
    logic [TRIG_BITS-1:0] trigger_reg;
    logic                 out_ready;
    logic                 take;

    assign take    = in_valid_reg && out_ready;
    assign s_ready = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            debounce_reg <= DEBOUNCE_RESET;
            trigger_reg  <= TRIGGER_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DEBOUNCE: debounce_reg <= cfg_wdata[DEB_BITS-1:0];
                    CFG_TRIGGER:  trigger_reg  <= cfg_wdata[TRIG_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    urc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .item        (in_data_reg),
        .debounce_us (debounce_reg),
        .trigger_us  (trigger_reg),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .out_ready   (out_ready)
    );

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.distance_mm <= DIST_MAX))
        else $error("distance out of range");

    a_stall_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && in_valid_reg))
        else $error("input blocked without output stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !in_valid_reg))
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
